// ===== hw/rtl/htpp_pkg.sv =====
// package: types, character codes and phase codes for the http target host/port parser
package htpp_pkg;

   localparam int CHAR_W  = 8;
   localparam int PORT_W  = 16;
   localparam int PHASE_W = 4;

   localparam logic [PORT_W-1:0] DEFAULT_PORT_RESET = 16'd80;
   localparam logic [PORT_W-1:0] PORT_MAX           = 16'hFFFF;
   localparam int                PORT_MUL_W         = PORT_W + 4;
   localparam logic [3:0]        DECIMAL_BASE       = 4'd10;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_AT    = 8'h40;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   // reported phase codes
   localparam logic [PHASE_W-1:0] PHASE_CODE_START      = 4'd0;
   localparam logic [PHASE_W-1:0] PHASE_CODE_COLON      = 4'd1;
   localparam logic [PHASE_W-1:0] PHASE_CODE_SLASH1     = 4'd2;
   localparam logic [PHASE_W-1:0] PHASE_CODE_AUTHORITY  = 4'd3;
   localparam logic [PHASE_W-1:0] PHASE_CODE_USERINFO   = 4'd4;
   localparam logic [PHASE_W-1:0] PHASE_CODE_PORT_START = 4'd5;
   localparam logic [PHASE_W-1:0] PHASE_CODE_PORT       = 4'd6;
   localparam logic [PHASE_W-1:0] PHASE_CODE_PATH       = 4'd7;
   localparam logic [PHASE_W-1:0] PHASE_CODE_END        = 4'd8;

   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   typedef enum logic [8:0] {
      PH_START      = 9'b000000001,
      PH_COLON      = 9'b000000010,
      PH_SLASH1     = 9'b000000100,
      PH_AUTHORITY  = 9'b000001000,
      PH_USERINFO   = 9'b000010000,
      PH_PORT_START = 9'b000100000,
      PH_PORT       = 9'b001000000,
      PH_PATH       = 9'b010000000,
      PH_END        = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic                host_byte_valid;
      logic [CHAR_W-1:0]   host_byte;
      logic                host_clear;
      logic [PORT_W-1:0]   port_value;
      logic [PHASE_W-1:0]  phase;
      logic                finished;
      logic                accepted;
   } rsp_type;

   function automatic logic [PHASE_W-1:0] phase_code(input phase_type ph);
      logic [PHASE_W-1:0] code;
      unique case (ph)
         PH_START:      code = PHASE_CODE_START;
         PH_COLON:      code = PHASE_CODE_COLON;
         PH_SLASH1:     code = PHASE_CODE_SLASH1;
         PH_AUTHORITY:  code = PHASE_CODE_AUTHORITY;
         PH_USERINFO:   code = PHASE_CODE_USERINFO;
         PH_PORT_START: code = PHASE_CODE_PORT_START;
         PH_PORT:       code = PHASE_CODE_PORT;
         PH_PATH:       code = PHASE_CODE_PATH;
         PH_END:        code = PHASE_CODE_END;
         default:       code = PHASE_CODE_PATH;
      endcase
      return code;
   endfunction

endpackage

// ===== hw/rtl/htpp_if.sv =====
// channel interfaces: request beats in, response beats out
interface htpp_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [htpp_pkg::CHAR_W-1:0] char_in;

   modport source (output valid, output kind, output char_in, input ready);
   modport sink   (input valid, input kind, input char_in, output ready);
endinterface

interface htpp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         host_byte_valid;
   logic [htpp_pkg::CHAR_W-1:0]  host_byte;
   logic                         host_clear;
   logic [htpp_pkg::PORT_W-1:0]  port_value;
   logic [htpp_pkg::PHASE_W-1:0] phase;
   logic                         finished;
   logic                         accepted;

   modport source (output valid, output host_byte_valid, output host_byte, output host_clear,
                   output port_value, output phase, output finished, output accepted,
                   input ready);
   modport sink   (input valid, input host_byte_valid, input host_byte, input host_clear,
                   input port_value, input phase, input finished, input accepted,
                   output ready);
endinterface

// ===== hw/rtl/htpp_step.sv =====
// next phase, next port and response fields for one target byte
module htpp_step (
   input  htpp_pkg::phase_type               phase_ff,
   input  logic [htpp_pkg::PORT_W-1:0]       port_ff,
   input  logic [htpp_pkg::PORT_W-1:0]       default_port,
   input  logic                              kind,
   input  logic [htpp_pkg::CHAR_W-1:0]       char_in,
   output htpp_pkg::phase_type               phase_in,
   output logic [htpp_pkg::PORT_W-1:0]       port_in,
   output htpp_pkg::rsp_type                 result
);
   import htpp_pkg::*;

   logic                  is_digit;
   logic [3:0]            digit;
   logic [PORT_MUL_W-1:0] port_mul;
   logic [PORT_W-1:0]     port_sat;
   logic                  hv;
   logic                  hc;
   logic                  acc;

   assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign digit    = 4'(char_in - CHAR_ZERO);
   // port * 10 + digit, saturating
   assign port_mul = PORT_MUL_W'(port_ff) * PORT_MUL_W'(DECIMAL_BASE) + PORT_MUL_W'(digit);
   assign port_sat = (port_mul > PORT_MUL_W'(PORT_MAX)) ? PORT_MAX : port_mul[PORT_W-1:0];

   always_comb begin
      phase_in = phase_ff;
      port_in  = port_ff;
      hv       = 1'b0;
      hc       = 1'b0;
      acc      = 1'b1;
      if (kind == KIND_RESTART) begin
         phase_in = PH_START;
         port_in  = default_port;
         hc       = 1'b1;
      end else if (phase_ff == PH_END) begin
         acc = 1'b0;
      end else if (char_in == CHAR_SPACE) begin
         phase_in = PH_END;
      end else begin
         unique case (phase_ff)
            PH_START: begin
               if (char_in == CHAR_SLASH) begin
                  phase_in = PH_PATH;
                  hc       = 1'b1;
               end else if (char_in == CHAR_COLON) begin
                  phase_in = PH_COLON;
               end else begin
                  hv = 1'b1;
               end
            end
            PH_COLON: begin
               if (is_digit) begin
                  phase_in = PH_PORT;
                  port_in  = PORT_W'(digit);
               end else if (char_in == CHAR_SLASH) begin
                  phase_in = PH_SLASH1;
                  hc       = 1'b1;
               end else begin
                  phase_in = PH_PATH;
                  hc       = 1'b1;
               end
            end
            PH_SLASH1: begin
               phase_in = (char_in == CHAR_SLASH) ? PH_AUTHORITY : PH_PATH;
            end
            PH_AUTHORITY: begin
               if (char_in == CHAR_COLON) begin
                  phase_in = PH_PORT_START;
               end else if (char_in == CHAR_AT) begin
                  phase_in = PH_USERINFO;
                  hc       = 1'b1;
               end else if (char_in == CHAR_SLASH) begin
                  phase_in = PH_PATH;
               end else begin
                  hv = 1'b1;
               end
            end
            PH_USERINFO: begin
               if (char_in == CHAR_COLON) begin
                  phase_in = PH_PORT_START;
               end else if (char_in == CHAR_SLASH) begin
                  phase_in = PH_PATH;
               end else begin
                  hv = 1'b1;
               end
            end
            PH_PORT_START: begin
               if (is_digit) begin
                  phase_in = PH_PORT;
                  port_in  = PORT_W'(digit);
               end else begin
                  phase_in = PH_PATH;
               end
            end
            PH_PORT: begin
               if (is_digit) begin
                  port_in = port_sat;
               end else begin
                  phase_in = PH_PATH;
                  if (char_in != CHAR_SLASH) begin
                     port_in = default_port;
                  end
               end
            end
            default: begin
               phase_in = PH_PATH;
            end
         endcase
      end
   end

   always_comb begin
      result.host_byte_valid = hv;
      result.host_byte       = hv ? char_in : '0;
      result.host_clear      = hc;
      result.port_value      = port_in;
      result.phase           = phase_code(phase_in);
      result.finished        = (phase_in == PH_END);
      result.accepted        = acc;
   end

endmodule

// ===== hw/rtl/http_target_host_port_parser_core.sv =====
// top level of the http request target host/port parser
// each beat moves from input register into result register; parse state advances on that move
// throughput: one beat per cycle unless rsp_ch.ready back pressure stalls the result register
// a new request beat is taken while a finished response still waits on rsp_ch.ready
// reset (synchronous, active high): both stages empty, phase start, port and default port 80
module http_target_host_port_parser_core (
   input  logic                          clock,
   input  logic                          reset,
   htpp_req_if.sink                      req_ch,
   htpp_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [htpp_pkg::PORT_W-1:0]   csr_wr_data
);
   import htpp_pkg::*;

   // input stage
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_kind_ff;
   logic [CHAR_W-1:0] s1_char_ff;

   // parse state
   phase_type         phase_ff;
   phase_type         phase_in;
   logic [PORT_W-1:0] port_ff;
   logic [PORT_W-1:0] port_in;
   logic [PORT_W-1:0] default_port_ff;

   // result stage
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           step_result;

   logic              s1_advance;
   logic              req_take;

   // s1 moves forward when the result register is empty or being drained
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ch.ready);

   htpp_step u_step (
      .phase_ff     (phase_ff),
      .port_ff      (port_ff),
      .default_port (default_port_ff),
      .kind         (s1_kind_ff),
      .char_in      (s1_char_ff),
      .phase_in     (phase_in),
      .port_in      (port_in),
      .result       (step_result)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_START;
         port_ff         <= DEFAULT_PORT_RESET;
         default_port_ff <= DEFAULT_PORT_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // state commits only when the beat leaves the input stage
         if (s1_advance) begin
            phase_ff <= phase_in;
            port_ff  <= port_in;
         end
         // user must land register writes only while idle, unenforced; port_ff keeps its value
         if (csr_wr_en) begin
            default_port_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff <= req_ch.kind;
         s1_char_ff <= req_ch.char_in;
      end
      if (s1_advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.host_byte_valid = rsp_data_ff.host_byte_valid;
   assign rsp_ch.host_byte       = rsp_data_ff.host_byte;
   assign rsp_ch.host_clear      = rsp_data_ff.host_clear;
   assign rsp_ch.port_value      = rsp_data_ff.port_value;
   assign rsp_ch.phase           = rsp_data_ff.phase;
   assign rsp_ch.finished        = rsp_data_ff.finished;
   assign rsp_ch.accepted        = rsp_data_ff.accepted;

   // a host byte is never dropped and never refused in the same beat
   a_host_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.host_byte_valid |-> !rsp_ch.host_clear && rsp_ch.accepted)
      else $error("host byte beat also clears or is refused");

   // finished tracks the end phase code
   a_finished_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.finished == (rsp_ch.phase == PHASE_CODE_END)))
      else $error("finished flag disagrees with phase");

   // once ended, a plain byte is refused and leaves the state alone
   a_end_sticky: assert property (@(posedge clock) disable iff (reset)
      s1_advance && (phase_ff == PH_END) && (s1_kind_ff == KIND_BYTE)
      |=> rsp_valid_ff && !rsp_data_ff.accepted && (phase_ff == PH_END)
          && (port_ff == $past(port_ff)))
      else $error("byte after end changed parse state");

   // a stalled input stage only happens behind a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |-> rsp_valid_ff && !rsp_ch.ready)
      else $error("input stage stalled without back pressure");

endmodule

// ===== tb/http_target_host_port_parser_core_test.sv =====
// self-checking testbench for the http request target host/port parser core
module http_target_host_port_parser_core_test;
   import htpp_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 11;
   localparam int STALL_LIMIT  = 2000;  // cycles with no beat moving on either channel
   localparam int LONG_HOLD    = 400;   // receiver hold-off that fills the pipeline
   localparam int IDLE_SETTLE  = 2;     // pipeline depth, waited out before a csr write
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 10;
   localparam int SWEEP_BEATS  = 300;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [PORT_W-1:0]   csr_wr_data = '0;

   htpp_req_if req_ch ();
   htpp_rsp_if rsp_ch ();

   http_target_host_port_parser_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // parser shadow state, advanced once per accepted request beat
   // ------------------------------------------------------------------
   logic [PHASE_W-1:0] parse_state      = PHASE_CODE_START;
   logic [PORT_W-1:0]  port_sum         = DEFAULT_PORT_RESET;
   logic [PORT_W-1:0]  default_port_reg = DEFAULT_PORT_RESET;

   rsp_type            pending_parse_results[$];   // one per accepted beat, oldest first
   logic [CHAR_W-1:0]  target_text[$];             // bytes of the target being built
   int unsigned        beats_sent = 0;
   int unsigned        burst_left = 0;
   int unsigned        failures = 0;
   int unsigned        long_stall_request = 0;     // picked up by the receiver process

   // next parse step for one beat; updates the shadow state
   function automatic rsp_type parse_target_byte(input logic kind,
                                                 input logic [CHAR_W-1:0] ch);
      rsp_type            r;
      logic [PHASE_W-1:0] nxt;
      logic               is_num;
      int unsigned        grown;
      r          = '0;
      r.accepted = 1'b1;
      nxt        = parse_state;
      is_num     = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      grown      = 32'(port_sum) * 32'(DECIMAL_BASE) + 32'(ch) - 32'(CHAR_ZERO);
      if (kind == KIND_RESTART) begin
         // new target: back to start, port reloads from the register
         nxt          = PHASE_CODE_START;
         port_sum     = default_port_reg;
         r.host_clear = 1'b1;
      end else if (parse_state == PHASE_CODE_END) begin
         // parsing is over, byte refused and nothing moves
         r.accepted = 1'b0;
      end else if (ch == CHAR_SPACE) begin
         nxt = PHASE_CODE_END;
      end else begin
         case (parse_state)
            PHASE_CODE_START: begin
               if (ch == CHAR_SLASH) begin
                  nxt          = PHASE_CODE_PATH;
                  r.host_clear = 1'b1;
               end else if (ch == CHAR_COLON) begin
                  nxt = PHASE_CODE_COLON;
               end else begin
                  r.host_byte_valid = 1'b1;
               end
            end
            PHASE_CODE_COLON: begin
               // digits mean host:port, anything else means the host was a scheme
               if (is_num) begin
                  nxt      = PHASE_CODE_PORT;
                  port_sum = PORT_W'(ch - CHAR_ZERO);
               end else if (ch == CHAR_SLASH) begin
                  nxt          = PHASE_CODE_SLASH1;
                  r.host_clear = 1'b1;
               end else begin
                  nxt          = PHASE_CODE_PATH;
                  r.host_clear = 1'b1;
               end
            end
            PHASE_CODE_SLASH1: begin
               nxt = (ch == CHAR_SLASH) ? PHASE_CODE_AUTHORITY : PHASE_CODE_PATH;
            end
            PHASE_CODE_AUTHORITY: begin
               if (ch == CHAR_COLON) begin
                  nxt = PHASE_CODE_PORT_START;
               end else if (ch == CHAR_AT) begin
                  // what came so far was user info
                  nxt          = PHASE_CODE_USERINFO;
                  r.host_clear = 1'b1;
               end else if (ch == CHAR_SLASH) begin
                  nxt = PHASE_CODE_PATH;
               end else begin
                  r.host_byte_valid = 1'b1;
               end
            end
            PHASE_CODE_USERINFO: begin
               if (ch == CHAR_COLON) begin
                  nxt = PHASE_CODE_PORT_START;
               end else if (ch == CHAR_SLASH) begin
                  nxt = PHASE_CODE_PATH;
               end else begin
                  r.host_byte_valid = 1'b1;
               end
            end
            PHASE_CODE_PORT_START: begin
               if (is_num) begin
                  nxt      = PHASE_CODE_PORT;
                  port_sum = PORT_W'(ch - CHAR_ZERO);
               end else begin
                  nxt = PHASE_CODE_PATH;
               end
            end
            PHASE_CODE_PORT: begin
               if (is_num) begin
                  // saturate instead of wrapping
                  port_sum = (grown > 32'(PORT_MAX)) ? PORT_MAX : grown[PORT_W-1:0];
               end else begin
                  nxt = PHASE_CODE_PATH;
                  // a slash keeps the digits, any other terminator falls back
                  if (ch != CHAR_SLASH) begin
                     port_sum = default_port_reg;
                  end
               end
            end
            default: begin
               nxt = PHASE_CODE_PATH;
            end
         endcase
      end
      parse_state  = nxt;
      r.host_byte  = r.host_byte_valid ? ch : '0;
      r.port_value = port_sum;
      r.phase      = nxt;
      r.finished   = (nxt == PHASE_CODE_END);
      return r;
   endfunction

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endtask

   // ------------------------------------------------------------------
   // request side: bursts of beats separated by random gaps
   // ------------------------------------------------------------------
   task automatic send_beat(input logic kind, input logic [CHAR_W-1:0] ch);
      int unsigned gap;
      if (burst_left == 0) begin
         // mostly short bursts, now and then a long stretch with no idling
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid   <= 1'b1;
      req_ch.kind    <= kind;
      req_ch.char_in <= ch;
      // valid stays up after the accept; the next call or a pause lowers it
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_parse_results.push_back(parse_target_byte(kind, ch));
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_beat(KIND_BYTE, s[i]);
      end
   endtask

   // csr write only with the pipeline empty
   task automatic write_default_port(input logic [PORT_W-1:0] value);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_parse_results.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      default_port_reg = value;
   endtask

   // ------------------------------------------------------------------
   // random target builder
   // ------------------------------------------------------------------
   // byte that is plain host text in every host-like phase
   function automatic logic [CHAR_W-1:0] pick_plain_char();
      logic [CHAR_W-1:0] c;
      do begin
         c = CHAR_W'($urandom_range(0, 255));
      end while (c == CHAR_SPACE || c == CHAR_SLASH || c == CHAR_COLON || c == CHAR_AT);
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_non_space();
      logic [CHAR_W-1:0] c;
      do begin
         c = CHAR_W'($urandom_range(0, 255));
      end while (c == CHAR_SPACE);
      return c;
   endfunction

   task automatic push_plain(input int unsigned n);
      repeat (n) target_text.push_back(pick_plain_char());
   endtask

   task automatic push_port();
      // up to six digits so that saturation shows up often
      repeat ($urandom_range(1, 6)) begin
         target_text.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
      end
   endtask

   task automatic compose_target();
      int unsigned      form;
      logic [CHAR_W-1:0] junk;
      target_text.delete();
      form = $urandom_range(0, 3);
      case (form)
         0: begin
            // host[:port]
            push_plain($urandom_range(1, 8));
            if ($urandom_range(0, 3) != 0) begin
               target_text.push_back(CHAR_COLON);
               push_port();
            end
         end
         1: begin
            // scheme://[user@]host[:port]
            push_plain($urandom_range(1, 5));
            target_text.push_back(CHAR_COLON);
            target_text.push_back(CHAR_SLASH);
            target_text.push_back(CHAR_SLASH);
            if ($urandom_range(0, 1) == 0) begin
               push_plain($urandom_range(1, 4));
               target_text.push_back(CHAR_AT);
            end
            push_plain($urandom_range(1, 8));
            if ($urandom_range(0, 2) != 0) begin
               target_text.push_back(CHAR_COLON);
               push_port();
            end
         end
         2: ;  // origin form, path only
         default: begin
            // scheme with a single slash, drops into the path
            push_plain($urandom_range(0, 3));
            target_text.push_back(CHAR_COLON);
            target_text.push_back(CHAR_SLASH);
            target_text.push_back(pick_plain_char());
         end
      endcase
      // tail: path, a junk terminator, or nothing
      if (form == 2 || $urandom_range(0, 1) == 0) begin
         target_text.push_back(CHAR_SLASH);
         repeat ($urandom_range(0, 6)) target_text.push_back(pick_non_space());
      end else if ($urandom_range(0, 1) == 0) begin
         do begin
            junk = pick_non_space();
         end while (junk >= CHAR_ZERO && junk <= CHAR_NINE);
         target_text.push_back(junk);
      end
      if ($urandom_range(0, 7) != 0) begin
         target_text.push_back(CHAR_SPACE);
         // trailing bytes after the end get refused
         repeat ($urandom_range(0, 2)) target_text.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      // broken target now and then
      if ($urandom_range(0, 5) == 0) begin
         target_text[$urandom_range(0, target_text.size() - 1)] =
            CHAR_W'($urandom_range(0, 255));
      end
   endtask

   task automatic run_random_targets(input int unsigned budget);
      int unsigned stop_at;
      stop_at = beats_sent + budget;
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 5) == 0) begin
            // raw noise, restarts sprinkled in
            repeat ($urandom_range(1, 12)) begin
               send_beat(($urandom_range(0, 15) == 0) ? KIND_RESTART : KIND_BYTE,
                         CHAR_W'($urandom_range(0, 255)));
            end
         end else begin
            compose_target();
            send_beat(KIND_RESTART, CHAR_W'($urandom_range(0, 255)));
            foreach (target_text[i]) send_beat(KIND_BYTE, target_text[i]);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // host:port at reset default, byte extremes, saturation, slash keeps
   // digits, end on space, bytes after end refused
   task automatic test_basic_target();
      send_beat(KIND_RESTART, 8'hA5);
      send_text("h");
      send_beat(KIND_BYTE, 8'h00);
      send_beat(KIND_BYTE, 8'hFF);
      send_beat(KIND_BYTE, CHAR_COLON);
      repeat (5) send_beat(KIND_BYTE, CHAR_NINE);
      send_beat(KIND_BYTE, CHAR_SLASH);
      send_text("x ");
      send_text("z");
      send_beat(KIND_BYTE, 8'hFF);
   endtask

   // scheme, user info, authority; default changed mid-target, then a port
   // ended by a non-digit falls back to the new value
   task automatic test_config_mid_target();
      send_beat(KIND_RESTART, 8'h00);
      send_text("s://u@h:");
      write_default_port(PORT_MAX);
      send_text("7q");
   endtask

   task automatic test_port_register_sweep();
      logic [PORT_W-1:0] sweep_values[5];
      sweep_values[0] = '0;
      sweep_values[1] = 16'd1;
      sweep_values[2] = PORT_W'($urandom_range(2, 65534));
      sweep_values[3] = PORT_MAX;
      sweep_values[4] = DEFAULT_PORT_RESET;
      foreach (sweep_values[i]) begin
         write_default_port(sweep_values[i]);
         run_random_targets(SWEEP_BEATS);
      end
   endtask

   // receiver holds off for a long stretch while beats keep coming
   task automatic test_full_backpressure();
      burst_left = 1000;
      long_stall_request = LONG_HOLD;
      run_random_targets(150);
      burst_left = 0;
   endtask

   // ------------------------------------------------------------------
   // response side: ready pattern plus the long hold-off
   // ------------------------------------------------------------------
   initial begin : rsp_ready_driver
      int unsigned       held;
      int unsigned       slot;
      logic [15:0]       ready_pattern;
      held          = 0;
      slot          = 0;
      ready_pattern = '1;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_request != 0) begin
            held = long_stall_request;
            long_stall_request = 0;
         end
         if (held != 0) begin
            held--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (slot == 0) begin
               // always ready, random, or mostly ready
               case ($urandom_range(0, 2))
                  0:       ready_pattern = '1;
                  1:       ready_pattern = 16'($urandom);
                  default: ready_pattern = 16'($urandom | $urandom);
               endcase
               slot = 48;
            end
            slot--;
            rsp_ch.ready <= ready_pattern[4'(slot)];
         end
      end
   end

   // compare every response beat with the oldest expectation
   always @(posedge clock) begin : rsp_checker
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.host_byte_valid = rsp_ch.host_byte_valid;
         got.host_byte       = rsp_ch.host_byte;
         got.host_clear      = rsp_ch.host_clear;
         got.port_value      = rsp_ch.port_value;
         got.phase           = rsp_ch.phase;
         got.finished        = rsp_ch.finished;
         got.accepted        = rsp_ch.accepted;
         if (pending_parse_results.size() == 0) begin
            log_failure($sformatf("unexpected response beat at %0t", $time));
         end else begin
            want = pending_parse_results.pop_front();
            if (got.host_byte_valid !== want.host_byte_valid ||
                got.host_byte       !== want.host_byte       ||
                got.host_clear      !== want.host_clear      ||
                got.port_value      !== want.port_value      ||
                got.phase           !== want.phase           ||
                got.finished        !== want.finished        ||
                got.accepted        !== want.accepted) begin
               log_failure($sformatf(
                  {"mismatch at %0t: exp hv=%0d hb=%02h clr=%0d port=%0d ph=%0d fin=%0d",
                   " acc=%0d / got hv=%0d hb=%02h clr=%0d port=%0d ph=%0d fin=%0d acc=%0d"},
                  $time, want.host_byte_valid, want.host_byte, want.host_clear,
                  want.port_value, want.phase, want.finished, want.accepted,
                  got.host_byte_valid, got.host_byte, got.host_clear,
                  got.port_value, got.phase, got.finished, got.accepted));
            end
         end
      end
   end

   // watchdog: too long with no beat moving on either channel
   initial begin : accept_watchdog
      int unsigned quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("** http_target_host_port_parser_core: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      req_ch.valid   <= 1'b0;
      req_ch.kind    <= KIND_BYTE;
      req_ch.char_in <= '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_basic_target();
      test_config_mid_target();
      test_port_register_sweep();
      test_full_backpressure();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_parse_results.size() != 0) @(posedge clock);
      // catch any stray beat after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("** http_target_host_port_parser_core: PASSED **");
      end else begin
         $display("** http_target_host_port_parser_core: FAILED **");
      end
      $finish;
   end

endmodule
